>>> hw/rtl/lcse_pkg.sv
package lcse_pkg;

  localparam int MAX_LEDS_DEF = 1024;

  localparam int CH_W       = 8;
  localparam int IDX_IN_W   = 16;
  localparam int LEN_W      = 11;
  localparam int OFF_W      = 14;
  localparam int SPI_W      = 24;
  localparam int RATIO_W    = 16;
  localparam int DIVD_W     = CH_W + RATIO_W;
  localparam int DIV_STEPS  = 8;
  localparam int SLOT_W     = 2;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 48;

  // issue spacing: busy-counter reload value after each accepted item, three result slots each
  localparam int ITEM_GAP = 2;
  localparam int GAP_W    = 2;
  // register stages from input capture to lane result
  localparam int LAT      = 5;

  localparam logic [2:0] PAT_ZERO = 3'b001;
  localparam logic [2:0] PAT_ONE  = 3'b011;
  localparam logic [CH_W-1:0] FULL_SCALE = 8'd255;

  localparam logic [SLOT_W-1:0] SLOT_GREEN = 2'd0;
  localparam logic [SLOT_W-1:0] SLOT_RED   = 2'd1;
  localparam logic [SLOT_W-1:0] SLOT_BLUE  = 2'd2;

  localparam logic [CH_W-1:0]       BRIGHT_RST = 8'd255;
  localparam logic [IDX_IN_W-1:0]   SPLIT_RST  = 16'hFFFF;
  localparam logic [LEN_W-1:0]      LEN_RST    = 11'd0;
  localparam logic [CFG_DATA_W-1:0] RATIO_RST  = 48'h0000_0001_0001_0001;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BRIGHTNESS = 4'd0,
    REG_RATIO_EN   = 4'd1,
    REG_SPLIT_IDX  = 4'd2,
    REG_STRIP_LEN  = 4'd3,
    REG_SEG1_NUM   = 4'd4,
    REG_SEG1_DEN   = 4'd5,
    REG_SEG2_NUM   = 4'd6,
    REG_SEG2_DEN   = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [IDX_IN_W-1:0] led_index;
    logic [CH_W-1:0]     red_in;
    logic [CH_W-1:0]     green_in;
    logic [CH_W-1:0]     blue_in;
  } in_item_t;

  typedef struct packed {
    logic [OFF_W-1:0]  byte_offset;
    logic [SPI_W-1:0]  spi_word;
    logic [SLOT_W-1:0] channel_slot;
    logic [CH_W-1:0]   channel_value;
    logic              last_word;
    logic              index_error;
  } out_item_t;

  typedef struct packed {
    logic [RATIO_W-1:0] num;
    logic [RATIO_W-1:0] den;
    logic               bypass;
  } lane_ctl_t;

  typedef struct packed {
    logic ld;
    logic err;
  } mrg_ctl_t;

  function automatic logic [SPI_W-1:0] encode_channel(input logic [CH_W-1:0] v);
    logic [SPI_W-1:0] w;
    w = '0;
    for (int j = 0; j < CH_W; j++) begin
      w[3*(CH_W-1-j) +: 3] = v[j] ? PAT_ONE : PAT_ZERO;
    end
    return w;
  endfunction

endpackage

>>> hw/rtl/led_color_spi_encoder.sv
// LED color to SPI pattern encoder. One transaction on start/busy carries an LED index and an
// RGB color; busy is raised after each accepted transaction and holds off the next one until the
// gap counter runs down, a spacing set by the three result words each LED produces. Three lanes
// (red, green, blue) each scale by brightness/255 and optionally by num/den through a
// three-stage pipelined divider; the first result is on out_strobe after the lane pipeline
// and the merge output register, and the words follow in consecutive cycles as green, red,
// blue. An index at or beyond the strip length gives a single error result instead. Results
// cannot be stalled: out_data is valid only in the cycle out_strobe is high. cfg_ready is
// always high; configuration writes must only be issued while no transaction is in flight.
module led_color_spi_encoder
  import lcse_pkg::*;
#(
  parameter int MAX_LEDS = MAX_LEDS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_data,
  output logic                  out_strobe,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam logic [IDX_IN_W-1:0] MAX_LIM = IDX_IN_W'(MAX_LEDS);

  logic [CH_W-1:0]       brightness_r;
  logic                  ratio_en_r;
  logic [IDX_IN_W-1:0]   split_r;
  logic [LEN_W-1:0]      len_r;
  logic [CFG_DATA_W-1:0] s1_num_r, s1_den_r, s2_num_r, s2_den_r;

  logic [GAP_W-1:0]      gap_r, gap_nxt;
  logic                  accept;
  logic [IDX_IN_W-1:0]   limit;
  logic                  idx_err;

  logic [LAT-1:0]        vld_r;
  logic [LAT-1:0]        err_r;
  logic [IDX_W-1:0]      idx_r [LAT];
  logic                  seg1_r;
  logic                  en_r;

  lane_ctl_t             lane_ctl [3];
  logic [CH_W-1:0]       lane_ch  [3];
  logic [CH_W-1:0]       lane_out [3];
  mrg_ctl_t              mctl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r <= BRIGHT_RST;
      ratio_en_r   <= 1'b0;
      split_r      <= SPLIT_RST;
      len_r        <= LEN_RST;
      s1_num_r     <= RATIO_RST;
      s1_den_r     <= RATIO_RST;
      s2_num_r     <= RATIO_RST;
      s2_den_r     <= RATIO_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BRIGHTNESS: brightness_r <= cfg_data[CH_W-1:0];
        REG_RATIO_EN:   ratio_en_r   <= cfg_data[0];
        REG_SPLIT_IDX:  split_r      <= cfg_data[IDX_IN_W-1:0];
        REG_STRIP_LEN:  len_r        <= cfg_data[LEN_W-1:0];
        REG_SEG1_NUM:   s1_num_r     <= cfg_data;
        REG_SEG1_DEN:   s1_den_r     <= cfg_data;
        REG_SEG2_NUM:   s2_num_r     <= cfg_data;
        REG_SEG2_DEN:   s2_den_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // issue throttle
  assign accept = start && !busy;
  assign busy   = (gap_r != '0);

  always_comb begin
    gap_nxt = gap_r;
    priority if (accept) begin
      gap_nxt = GAP_W'(ITEM_GAP);
    end else if (gap_r != '0) begin
      gap_nxt = gap_r - 1'b1;
    end else begin
      gap_nxt = gap_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= '0;
    end else begin
      gap_r <= gap_nxt;
    end
  end

  // strip length is clamped to MAX_LEDS
  assign limit   = (IDX_IN_W'(len_r) > MAX_LIM) ? MAX_LIM : IDX_IN_W'(len_r);
  assign idx_err = (in_data.led_index >= limit);

  // transaction tag pipeline alongside the lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    err_r    <= {err_r[LAT-2:0], idx_err};
    idx_r[0] <= in_data.led_index[IDX_W-1:0];
    for (int s = 1; s < LAT; s++) begin
      idx_r[s] <= idx_r[s-1];
    end
    seg1_r <= (in_data.led_index < split_r);
    en_r   <= ratio_en_r;
  end

  assign lane_ch[0] = in_data.red_in;
  assign lane_ch[1] = in_data.green_in;
  assign lane_ch[2] = in_data.blue_in;

  for (genvar k = 0; k < 3; k++) begin : g_lane
    assign lane_ctl[k].num    = seg1_r ? s1_num_r[RATIO_W*k +: RATIO_W]
                                       : s2_num_r[RATIO_W*k +: RATIO_W];
    assign lane_ctl[k].den    = seg1_r ? s1_den_r[RATIO_W*k +: RATIO_W]
                                       : s2_den_r[RATIO_W*k +: RATIO_W];
    assign lane_ctl[k].bypass = !en_r;

    lcse_lane u_lane (
      .clk          (clk),
      .ch_i         (lane_ch[k]),
      .brightness_i (brightness_r),
      .ctl_i        (lane_ctl[k]),
      .byte_o       (lane_out[k])
    );
  end

  assign mctl.ld  = vld_r[LAT-1];
  assign mctl.err = err_r[LAT-1];

  lcse_merge #(
    .MAX_LEDS (MAX_LEDS)
  ) u_merge (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl_i        (mctl),
    .idx_i        (idx_r[LAT-1]),
    .red_i        (lane_out[0]),
    .green_i      (lane_out[1]),
    .blue_i       (lane_out[2]),
    .out_strobe_o (out_strobe),
    .out_data_o   (out_data)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted transaction");

  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[LAT-1] |=> out_strobe)
    else $error("no result when lane data was ready");

  a_slot_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_data.index_error && out_data.channel_slot == SLOT_GREEN) |=>
    (out_strobe && out_data.channel_slot == SLOT_RED))
    else $error("red word did not follow green word");

endmodule

>>> hw/rtl/lcse_div_stage.sv
module lcse_div_stage
  import lcse_pkg::*;
(
  input  logic                 clk,
  input  logic [RATIO_W-1:0]   rem_i,
  input  logic [DIV_STEPS-1:0] bits_i,
  input  logic [RATIO_W-1:0]   den_i,
  output logic [RATIO_W-1:0]   rem_o,
  output logic [DIV_STEPS-1:0] q_o
);

  logic [RATIO_W-1:0]   rem_nxt, rem_r;
  logic [DIV_STEPS-1:0] q_nxt, q_r;
  logic [RATIO_W:0]     trial;

  // restoring division, one quotient bit per step, MSB first
  always_comb begin
    rem_nxt = rem_i;
    q_nxt   = '0;
    trial   = '0;
    for (int j = DIV_STEPS - 1; j >= 0; j--) begin
      trial = {rem_nxt, bits_i[j]};
      if (trial >= {1'b0, den_i}) begin
        trial    = trial - {1'b0, den_i};
        q_nxt[j] = 1'b1;
      end
      rem_nxt = trial[RATIO_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign rem_o = rem_r;
  assign q_o   = q_r;

endmodule

>>> hw/rtl/lcse_lane.sv
module lcse_lane
  import lcse_pkg::*;
(
  input  logic            clk,
  input  logic [CH_W-1:0] ch_i,
  input  logic [CH_W-1:0] brightness_i,
  input  lane_ctl_t       ctl_i,
  output logic [CH_W-1:0] byte_o
);

  logic [2*CH_W-1:0]   prod_r;
  logic [2*CH_W:0]     scl_sum;
  logic [CH_W-1:0]     scaled;

  logic [DIVD_W-1:0]   dvd_r;
  logic [RATIO_W-1:0]  den2_r, den3_r, den4_r;
  logic [CH_W-1:0]     val2_r, val3_r, val4_r, val5_r;
  logic                byp2_r, byp3_r, byp4_r, byp5_r;
  logic                dz2_r, dz3_r, dz4_r, dz5_r;
  logic [2*CH_W-1:0]   lo1_r;
  logic [CH_W-1:0]     lo2_r;
  logic [RATIO_W-1:0]  rem1, rem2;
  logic [CH_W-1:0]     quo;

  // x/255 for x <= 255*255: (x + (x>>8) + 1) >> 8
  assign scl_sum = {1'b0, prod_r} + {{(CH_W+1){1'b0}}, prod_r[2*CH_W-1:CH_W]} + 17'd1;
  assign scaled  = scl_sum[2*CH_W-1:CH_W];

  always_ff @(posedge clk) begin
    prod_r <= (2*CH_W)'(ch_i) * (2*CH_W)'(brightness_i);

    dvd_r  <= DIVD_W'(scaled) * DIVD_W'(ctl_i.num);
    den2_r <= ctl_i.den;
    val2_r <= scaled;
    byp2_r <= ctl_i.bypass;
    dz2_r  <= (ctl_i.den == '0);

    lo1_r  <= dvd_r[2*CH_W-1:0];
    den3_r <= den2_r;
    val3_r <= val2_r;
    byp3_r <= byp2_r;
    dz3_r  <= dz2_r;

    lo2_r  <= lo1_r[CH_W-1:0];
    den4_r <= den3_r;
    val4_r <= val3_r;
    byp4_r <= byp3_r;
    dz4_r  <= dz3_r;

    val5_r <= val4_r;
    byp5_r <= byp4_r;
    dz5_r  <= dz4_r;
  end

  lcse_div_stage u_div_hi (
    .clk    (clk),
    .rem_i  ('0),
    .bits_i (dvd_r[DIVD_W-1:2*CH_W]),
    .den_i  (den2_r),
    .rem_o  (rem1),
    .q_o    ()
  );

  lcse_div_stage u_div_mid (
    .clk    (clk),
    .rem_i  (rem1),
    .bits_i (lo1_r[2*CH_W-1:CH_W]),
    .den_i  (den3_r),
    .rem_o  (rem2),
    .q_o    ()
  );

  // only the low quotient byte is kept
  lcse_div_stage u_div_lo (
    .clk    (clk),
    .rem_i  (rem2),
    .bits_i (lo2_r),
    .den_i  (den4_r),
    .rem_o  (),
    .q_o    (quo)
  );

  assign byte_o = byp5_r ? val5_r : (dz5_r ? FULL_SCALE : quo);

endmodule

>>> hw/rtl/lcse_merge.sv
module lcse_merge
  import lcse_pkg::*;
#(
  parameter int MAX_LEDS = MAX_LEDS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mrg_ctl_t            ctl_i,
  input  logic [((MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1)-1:0] idx_i,
  input  logic [CH_W-1:0]     red_i,
  input  logic [CH_W-1:0]     green_i,
  input  logic [CH_W-1:0]     blue_i,
  output logic                out_strobe_o,
  output out_item_t           out_data_o
);

  localparam int IDX_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int SUM_W = (IDX_W + 4 > OFF_W) ? IDX_W + 4 : OFF_W;

  logic              act_r, act_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              strobe_r, strobe_nxt;
  logic [OFF_W-1:0]  base_r, base_nxt;
  logic [CH_W-1:0]   red_r, red_nxt, blue_r, blue_nxt;
  out_item_t         out_r, out_nxt;
  logic [SUM_W-1:0]  base_full;

  // index * 9
  assign base_full = SUM_W'({idx_i, 3'b000}) + SUM_W'(idx_i);

  function automatic out_item_t mk_word(input logic [OFF_W-1:0] base,
                                        input logic [SLOT_W-1:0] slot,
                                        input logic [CH_W-1:0] val);
    out_item_t w;
    w.byte_offset   = base + OFF_W'(slot) + OFF_W'({slot, 1'b0});
    w.spi_word      = encode_channel(val);
    w.channel_slot  = slot;
    w.channel_value = val;
    w.last_word     = (slot == SLOT_BLUE);
    w.index_error   = 1'b0;
    return w;
  endfunction

  always_comb begin
    act_nxt    = act_r;
    slot_nxt   = slot_r;
    strobe_nxt = 1'b0;
    base_nxt   = base_r;
    red_nxt    = red_r;
    blue_nxt   = blue_r;
    out_nxt    = out_r;
    priority if (ctl_i.ld) begin
      strobe_nxt = 1'b1;
      if (ctl_i.err) begin
        out_nxt             = '0;
        out_nxt.last_word   = 1'b1;
        out_nxt.index_error = 1'b1;
        act_nxt             = 1'b0;
      end else begin
        base_nxt = base_full[OFF_W-1:0];
        red_nxt  = red_i;
        blue_nxt = blue_i;
        out_nxt  = mk_word(base_full[OFF_W-1:0], SLOT_GREEN, green_i);
        act_nxt  = 1'b1;
        slot_nxt = SLOT_RED;
      end
    end else if (act_r) begin
      strobe_nxt = 1'b1;
      out_nxt    = mk_word(base_r, slot_r, (slot_r == SLOT_RED) ? red_r : blue_r);
      if (slot_r == SLOT_BLUE) begin
        act_nxt = 1'b0;
      end else begin
        slot_nxt = SLOT_BLUE;
      end
    end else begin
      strobe_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r    <= 1'b0;
      slot_r   <= SLOT_GREEN;
      strobe_r <= 1'b0;
    end else begin
      act_r    <= act_nxt;
      slot_r   <= slot_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    red_r  <= red_nxt;
    blue_r <= blue_nxt;
    out_r  <= out_nxt;
  end

  assign out_strobe_o = strobe_r;
  assign out_data_o   = out_r;

endmodule
